// ===== rtl/core/cmrt_pkg.sv =====
// ----------------------------------------------------------------------------
// CAN motor response tracker package
// Item codes, CAN response codes, register addresses and the cached entry type.
// ----------------------------------------------------------------------------
package cmrt_pkg;

  // Item function codes.
  localparam logic [1:0] FUNC_FRAME = 2'd0;
  localparam logic [1:0] FUNC_ADD   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  // Frame acceptance limits.
  localparam logic [3:0]  MIN_LENGTH   = 4'd2;
  localparam logic [3:0]  STATE_LENGTH = 4'd3;
  localparam logic [3:0]  WORD_LENGTH  = 4'd6;
  localparam logic [11:0] ID_LIMIT     = 12'h100;

  // Response types carried in data byte 0.
  localparam logic [7:0] RESP_WRITE_ACK = 8'h02;
  localparam logic [7:0] RESP_READ      = 8'h04;

  // Write ack states that mean success.
  localparam logic [7:0] ACK_OK      = 8'h01;
  localparam logic [7:0] ACK_OK_ALT  = 8'h05;

  // Device register addresses.
  localparam logic [7:0] REG_CURRENT   = 8'h05;
  localparam logic [7:0] REG_VELOCITY  = 8'h06;
  localparam logic [7:0] REG_POSITION  = 8'h07;
  localparam logic [7:0] REG_SET_VEL   = 8'h09;
  localparam logic [7:0] REG_SET_POS   = 8'h0A;
  localparam logic [7:0] REG_MODE      = 8'h0F;
  localparam logic [7:0] REG_ENABLE    = 8'h10;
  localparam logic [7:0] REG_ALARM     = 8'h15;

  // Mode byte value that selects velocity mode.
  localparam logic [7:0] MODE_VELOCITY = 8'h03;

  // Bit positions in the flag word.
  localparam int FLAG_VEL_MODE = 0;
  localparam int FLAG_ENABLED  = 1;
  localparam int FLAG_FAULT    = 2;
  localparam int FLAG_POS_RX   = 3;
  localparam int FLAG_CUR_RX   = 4;
  localparam int FLAG_VEL_RX   = 5;

  typedef struct packed {
    logic [31:0] position;
    logic [31:0] current;
    logic [31:0] speed;
    logic [5:0]  flags;
  } entry_t;

  // Saturates a 32-bit two's complement value to 16 bits.
  function automatic logic [15:0] sat16(input logic [31:0] raw);
    logic [15:0] res;
    if ((&raw[31:15]) || !(|raw[31:15])) begin
      res = raw[15:0];
    end else if (raw[31]) begin
      res = 16'h8000;
    end else begin
      res = 16'h7FFF;
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/can_motor_response_tracker_top.sv =====
// ----------------------------------------------------------------------------
// CAN motor response tracker
// Caches per-motor current, velocity, position and status from CAN responses.
// ----------------------------------------------------------------------------
// An item is registered into stage 1; done and the result word are registered
// from stage 1. Throughput: one item per cycle; busy stays low.
// Every item gives exactly one result, shown for one cycle with done.
// Synchronous reset clears the managed set, the entry valid bits and the
// pipeline; a motor entry reads as zero until its first accepted frame.
module can_motor_response_tracker_top #(
  parameter int MOTOR_SLOTS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         func,
  input  logic               is_extended,
  input  logic [10:0]        frame_id,
  input  logic [3:0]         frame_length,
  input  logic [7:0]         response_type,
  input  logic [7:0]         register_addr,
  input  logic [31:0]        payload_word,
  input  logic [7:0]         managed_id,
  output logic               done,
  output logic               accepted,
  output logic [7:0]         motor_id,
  output logic signed [31:0] position,
  output logic signed [15:0] current_ma,
  output logic signed [15:0] speed,
  output logic               velocity_mode,
  output logic               enabled,
  output logic               fault,
  output logic [2:0]         received_mask,
  output logic               write_failed,
  output logic               resync_valid,
  output logic [7:0]         resync_register
);

  localparam int IDW = (MOTOR_SLOTS > 1) ? $clog2(MOTOR_SLOTS) : 1;
  localparam logic [11:0] SLOT_LIMIT = 12'(MOTOR_SLOTS);
  localparam logic [8:0]  ADD_LIMIT  = 9'(MOTOR_SLOTS);

  logic take_item;
  logic frame_ok;
  logic is_managed;

  logic [MOTOR_SLOTS-1:0] managed_map;
  logic                   any_managed;
  logic [MOTOR_SLOTS-1:0] entry_valid;

  cmrt_pkg::entry_t mem [MOTOR_SLOTS];
  cmrt_pkg::entry_t rd_entry;

  // Stage 1 registers.
  logic           s1_valid;
  logic           s1_take;
  logic [IDW-1:0] s1_id;
  logic [7:0]     s1_rtype;
  logic [7:0]     s1_reg;
  logic [31:0]    s1_word;
  logic           s1_ge3;
  logic           s1_ge6;

  // Last write, forwarded to a following frame for the same motor.
  logic             fwd_valid;
  logic [IDW-1:0]   fwd_id;
  cmrt_pkg::entry_t fwd_entry;

  cmrt_pkg::entry_t e_old;
  cmrt_pkg::entry_t e_new;
  logic             failed;
  logic             rs_valid;
  logic [7:0]       rs_reg;
  logic [31:0]      word_rd;
  logic [7:0]       state_byte;
  logic [7:0]       low_byte;

  assign busy      = 1'b0;
  assign take_item = start && !busy;

  // A nonempty managed set always has a nonzero count, so one flag stands for it.
  assign is_managed = !any_managed || managed_map[frame_id[IDW-1:0]];
  assign frame_ok   = (func == cmrt_pkg::FUNC_FRAME) && !is_extended &&
                      (frame_length >= cmrt_pkg::MIN_LENGTH) &&
                      ({1'b0, frame_id} < cmrt_pkg::ID_LIMIT) &&
                      ({1'b0, frame_id} < SLOT_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      managed_map <= '0;
      any_managed <= 1'b0;
    end else if (take_item) begin
      if (func == cmrt_pkg::FUNC_ADD && {1'b0, managed_id} < ADD_LIMIT) begin
        managed_map[managed_id[IDW-1:0]] <= 1'b1;
        any_managed                      <= 1'b1;
      end else if (func == cmrt_pkg::FUNC_CLEAR) begin
        managed_map <= '0;
        any_managed <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_take  <= 1'b0;
    end else begin
      s1_valid <= take_item;
      s1_take  <= take_item && frame_ok && is_managed;
    end
  end

  always_ff @(posedge clk) begin
    s1_id    <= frame_id[IDW-1:0];
    s1_rtype <= response_type;
    s1_reg   <= register_addr;
    s1_word  <= payload_word;
    s1_ge3   <= frame_length >= cmrt_pkg::STATE_LENGTH;
    s1_ge6   <= frame_length >= cmrt_pkg::WORD_LENGTH;
  end

  always_ff @(posedge clk) begin
    rd_entry <= mem[frame_id[IDW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      mem[s1_id] <= e_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      fwd_valid   <= 1'b0;
    end else begin
      if (s1_take) begin
        entry_valid[s1_id] <= 1'b1;
      end
      fwd_valid <= s1_take;
    end
  end

  always_ff @(posedge clk) begin
    fwd_id    <= s1_id;
    fwd_entry <= e_new;
  end

  always_comb begin
    if (fwd_valid && fwd_id == s1_id) begin
      e_old = fwd_entry;
    end else if (entry_valid[s1_id]) begin
      e_old = rd_entry;
    end else begin
      e_old = '0;
    end
  end

  // Bytes beyond the length code read as zero.
  assign word_rd    = s1_ge6 ? s1_word : 32'd0;
  assign state_byte = s1_ge3 ? s1_word[31:24] : 8'd0;
  assign low_byte   = s1_ge6 ? s1_word[7:0] : 8'd0;

  always_comb begin
    e_new    = e_old;
    failed   = 1'b0;
    rs_valid = 1'b0;
    rs_reg   = 8'd0;
    case (s1_rtype)
      cmrt_pkg::RESP_WRITE_ACK: begin
        if (state_byte != cmrt_pkg::ACK_OK && state_byte != cmrt_pkg::ACK_OK_ALT) begin
          failed   = 1'b1;
          rs_valid = 1'b1;
          case (s1_reg)
            cmrt_pkg::REG_SET_VEL: rs_reg = cmrt_pkg::REG_VELOCITY;
            cmrt_pkg::REG_SET_POS: rs_reg = cmrt_pkg::REG_POSITION;
            cmrt_pkg::REG_MODE:    rs_reg = cmrt_pkg::REG_MODE;
            cmrt_pkg::REG_ENABLE:  rs_reg = cmrt_pkg::REG_ENABLE;
            cmrt_pkg::REG_ALARM:   rs_reg = cmrt_pkg::REG_CURRENT;
            default:               rs_valid = 1'b0;
          endcase
        end
      end
      cmrt_pkg::RESP_READ: begin
        case (s1_reg)
          cmrt_pkg::REG_CURRENT: begin
            e_new.current                      = word_rd;
            e_new.flags[cmrt_pkg::FLAG_CUR_RX] = 1'b1;
          end
          cmrt_pkg::REG_VELOCITY: begin
            e_new.speed                        = word_rd;
            e_new.flags[cmrt_pkg::FLAG_VEL_RX] = 1'b1;
          end
          cmrt_pkg::REG_POSITION: begin
            e_new.position                     = word_rd;
            e_new.flags[cmrt_pkg::FLAG_POS_RX] = 1'b1;
          end
          cmrt_pkg::REG_MODE: begin
            e_new.flags[cmrt_pkg::FLAG_VEL_MODE] = (low_byte == cmrt_pkg::MODE_VELOCITY);
          end
          cmrt_pkg::REG_ENABLE: begin
            e_new.flags[cmrt_pkg::FLAG_ENABLED] = (low_byte != 8'd0);
          end
          cmrt_pkg::REG_ALARM: begin
            e_new.flags[cmrt_pkg::FLAG_FAULT] = (word_rd != 32'd0);
          end
          default: begin
            e_new = e_old;
          end
        endcase
      end
      default: begin
        e_new = e_old;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      accepted        <= 1'b1;
      motor_id        <= 8'(s1_id);
      position        <= e_new.position;
      current_ma      <= cmrt_pkg::sat16(e_new.current);
      speed           <= cmrt_pkg::sat16(e_new.speed);
      velocity_mode   <= e_new.flags[cmrt_pkg::FLAG_VEL_MODE];
      enabled         <= e_new.flags[cmrt_pkg::FLAG_ENABLED];
      fault           <= e_new.flags[cmrt_pkg::FLAG_FAULT];
      received_mask   <= {e_new.flags[cmrt_pkg::FLAG_VEL_RX],
                          e_new.flags[cmrt_pkg::FLAG_CUR_RX],
                          e_new.flags[cmrt_pkg::FLAG_POS_RX]};
      write_failed    <= failed;
      resync_valid    <= rs_valid;
      resync_register <= rs_valid ? rs_reg : 8'd0;
    end else begin
      accepted        <= 1'b0;
      motor_id        <= 8'd0;
      position        <= '0;
      current_ma      <= '0;
      speed           <= '0;
      velocity_mode   <= 1'b0;
      enabled         <= 1'b0;
      fault           <= 1'b0;
      received_mask   <= 3'd0;
      write_failed    <= 1'b0;
      resync_valid    <= 1'b0;
      resync_register <= 8'd0;
    end
  end

endmodule

// ===== rtl/core/cmrt_checker.sv =====
// ----------------------------------------------------------------------------
// CAN motor response tracker checker
// Port-level checks on result timing and result word consistency.
// ----------------------------------------------------------------------------
module cmrt_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        accepted,
  input logic [7:0]  motor_id,
  input logic [31:0] position,
  input logic [15:0] current_ma,
  input logic [15:0] speed,
  input logic        velocity_mode,
  input logic        enabled,
  input logic        fault,
  input logic [2:0]  received_mask,
  input logic        write_failed,
  input logic        resync_valid,
  input logic [7:0]  resync_register
);

  // Every taken word produces a result word.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##2 done)
    else $error("result word missing after start");

  // No result word appears without a matching taken word.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result word without a matching start");

  // A rejected item reports an all-zero result word.
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    done && !accepted |-> motor_id == 8'd0 && position == 32'd0 &&
      current_ma == 16'd0 && speed == 16'd0 && !velocity_mode && !enabled &&
      !fault && received_mask == 3'd0 && !write_failed && !resync_valid)
    else $error("rejected item reported nonzero fields");

  // A resync request only follows a failed write, and names a register.
  a_resync_failed: assert property (@(posedge clk) disable iff (rst)
    done && resync_valid |-> write_failed && resync_register != 8'd0)
    else $error("resync request without a failed write");

  a_resync_reg_zero: assert property (@(posedge clk) disable iff (rst)
    done && !resync_valid |-> resync_register == 8'd0)
    else $error("resync register set without a request");

endmodule

bind can_motor_response_tracker_top cmrt_checker u_cmrt_checker (.*);

// ===== tb/sv/can_motor_response_tracker_top_tb.sv =====
// ----------------------------------------------------------------------------
// CAN motor response tracker testbench
// Sends frames and managed-set updates with random gaps and predicts every
// result word from a local copy of the per-motor cache and the managed set.
// Each result is checked field by field against the oldest expected word.
// ----------------------------------------------------------------------------
module can_motor_response_tracker_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MOTOR_SLOTS = 256;
  localparam int ITEM_TARGET = 1700;
  localparam int BLOCK_WORDS = 100;

  // Codes the tracker does not recognize.
  localparam logic [7:0] REG_UNKNOWN  = 8'h33;
  localparam logic [7:0] RESP_UNKNOWN = 8'h11;
  localparam logic [1:0] FUNC_UNUSED  = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic        is_extended;
    logic [10:0] frame_id;
    logic [3:0]  frame_length;
    logic [7:0]  response_type;
    logic [7:0]  register_addr;
    logic [31:0] payload_word;
    logic [7:0]  managed_id;
  } word_t;

  typedef struct packed {
    logic        accepted;
    logic [7:0]  motor_id;
    logic [31:0] position;
    logic [15:0] current_ma;
    logic [15:0] speed;
    logic        velocity_mode;
    logic        enabled;
    logic        fault;
    logic [2:0]  received_mask;
    logic        write_failed;
    logic        resync_valid;
    logic [7:0]  resync_register;
  } entry_report_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [1:0]         func;
  logic               is_extended;
  logic [10:0]        frame_id;
  logic [3:0]         frame_length;
  logic [7:0]         response_type;
  logic [7:0]         register_addr;
  logic [31:0]        payload_word;
  logic [7:0]         managed_id;
  logic               done;
  logic               accepted;
  logic [7:0]         motor_id;
  logic signed [31:0] position;
  logic signed [15:0] current_ma;
  logic signed [15:0] speed;
  logic               velocity_mode;
  logic               enabled;
  logic               fault;
  logic [2:0]         received_mask;
  logic               write_failed;
  logic               resync_valid;
  logic [7:0]         resync_register;

  can_motor_response_tracker_top #(
    .MOTOR_SLOTS(MOTOR_SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .is_extended(is_extended),
    .frame_id(frame_id),
    .frame_length(frame_length),
    .response_type(response_type),
    .register_addr(register_addr),
    .payload_word(payload_word),
    .managed_id(managed_id),
    .done(done),
    .accepted(accepted),
    .motor_id(motor_id),
    .position(position),
    .current_ma(current_ma),
    .speed(speed),
    .velocity_mode(velocity_mode),
    .enabled(enabled),
    .fault(fault),
    .received_mask(received_mask),
    .write_failed(write_failed),
    .resync_valid(resync_valid),
    .resync_register(resync_register)
  );

  // Local copy of the motor cache and the managed set.
  logic [31:0] pos_cache [MOTOR_SLOTS];
  logic [31:0] cur_cache [MOTOR_SLOTS];
  logic [31:0] spd_cache [MOTOR_SLOTS];
  logic [5:0]  flag_cache [MOTOR_SLOTS];
  bit          managed_map [MOTOR_SLOTS];
  logic [8:0]  managed_total;

  entry_report_t entry_reports_due[$];

  int gap_limit;
  int words_sent;
  int set_updates;
  int frames_taken;
  int resyncs_seen;
  int mismatch_count;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [15:0] clamp16(input logic [31:0] raw);
    int v;
    v = $signed(raw);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return raw[15:0];
  endfunction

  // Applies one word to the local cache and returns the result it must give.
  function automatic entry_report_t track_word(input word_t w);
    entry_report_t r;
    logic [31:0]   val;
    logic [7:0]    state_b;
    logic [7:0]    low_b;
    logic [5:0]    fl;
    int            id;
    r = '0;
    case (w.func)
      cmrt_pkg::FUNC_ADD: begin
        if (int'(w.managed_id) < MOTOR_SLOTS && !managed_map[w.managed_id]) begin
          managed_map[w.managed_id] = 1'b1;
          managed_total = managed_total + 9'd1;
        end
        return r;
      end
      cmrt_pkg::FUNC_CLEAR: begin
        for (int i = 0; i < MOTOR_SLOTS; i++) managed_map[i] = 1'b0;
        managed_total = '0;
        return r;
      end
      cmrt_pkg::FUNC_FRAME: ;
      default: return r;
    endcase

    if (w.is_extended || w.frame_length < cmrt_pkg::MIN_LENGTH ||
        {1'b0, w.frame_id} >= cmrt_pkg::ID_LIMIT)
      return r;
    id = int'(w.frame_id);
    if (id >= MOTOR_SLOTS) return r;
    if (managed_total != 0 && !managed_map[id]) return r;

    // Bytes past the length code read as zero.
    val     = (w.frame_length >= cmrt_pkg::WORD_LENGTH) ? w.payload_word : 32'd0;
    state_b = (w.frame_length >= cmrt_pkg::STATE_LENGTH) ? w.payload_word[31:24] : 8'd0;
    low_b   = (w.frame_length >= cmrt_pkg::WORD_LENGTH) ? w.payload_word[7:0] : 8'd0;
    fl = flag_cache[id];

    if (w.response_type == cmrt_pkg::RESP_WRITE_ACK) begin
      if (state_b != cmrt_pkg::ACK_OK && state_b != cmrt_pkg::ACK_OK_ALT) begin
        r.write_failed = 1'b1;
        r.resync_valid = 1'b1;
        case (w.register_addr)
          cmrt_pkg::REG_SET_VEL: r.resync_register = cmrt_pkg::REG_VELOCITY;
          cmrt_pkg::REG_SET_POS: r.resync_register = cmrt_pkg::REG_POSITION;
          cmrt_pkg::REG_MODE:    r.resync_register = cmrt_pkg::REG_MODE;
          cmrt_pkg::REG_ENABLE:  r.resync_register = cmrt_pkg::REG_ENABLE;
          // A failed alarm write is followed up by a read at the current address.
          cmrt_pkg::REG_ALARM:   r.resync_register = cmrt_pkg::REG_CURRENT;
          default:               r.resync_valid = 1'b0;
        endcase
      end
    end else if (w.response_type == cmrt_pkg::RESP_READ) begin
      case (w.register_addr)
        cmrt_pkg::REG_CURRENT: begin
          cur_cache[id] = val;
          fl[cmrt_pkg::FLAG_CUR_RX] = 1'b1;
        end
        cmrt_pkg::REG_VELOCITY: begin
          spd_cache[id] = val;
          fl[cmrt_pkg::FLAG_VEL_RX] = 1'b1;
        end
        cmrt_pkg::REG_POSITION: begin
          pos_cache[id] = val;
          fl[cmrt_pkg::FLAG_POS_RX] = 1'b1;
        end
        cmrt_pkg::REG_MODE:   fl[cmrt_pkg::FLAG_VEL_MODE] = (low_b == cmrt_pkg::MODE_VELOCITY);
        cmrt_pkg::REG_ENABLE: fl[cmrt_pkg::FLAG_ENABLED] = (low_b != 8'd0);
        cmrt_pkg::REG_ALARM:  fl[cmrt_pkg::FLAG_FAULT] = (val != 32'd0);
        default: ;
      endcase
    end
    flag_cache[id] = fl;

    r.accepted      = 1'b1;
    r.motor_id      = id[7:0];
    r.position      = pos_cache[id];
    r.current_ma    = clamp16(cur_cache[id]);
    r.speed         = clamp16(spd_cache[id]);
    r.velocity_mode = fl[cmrt_pkg::FLAG_VEL_MODE];
    r.enabled       = fl[cmrt_pkg::FLAG_ENABLED];
    r.fault         = fl[cmrt_pkg::FLAG_FAULT];
    r.received_mask = {fl[cmrt_pkg::FLAG_VEL_RX], fl[cmrt_pkg::FLAG_CUR_RX],
                       fl[cmrt_pkg::FLAG_POS_RX]};
    return r;
  endfunction

  function automatic word_t make_frame(input logic [10:0] fid, input logic [3:0] dlc,
                                       input logic [7:0] rtype, input logic [7:0] raddr,
                                       input logic [31:0] data);
    word_t w;
    w = '0;
    w.func          = cmrt_pkg::FUNC_FRAME;
    w.frame_id      = fid;
    w.frame_length  = dlc;
    w.response_type = rtype;
    w.register_addr = raddr;
    w.payload_word  = data;
    return w;
  endfunction

  function automatic word_t make_control(input logic [1:0] f, input logic [7:0] mid);
    word_t w;
    w = '0;
    w.func       = f;
    w.managed_id = mid;
    return w;
  endfunction

  // Most traffic goes to a few motors so that their entries build up history.
  function automatic logic [7:0] hot_motor();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return 8'($urandom_range(0, 3));
      6:       return 8'h7F;
      7:       return 8'h80;
      8:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_register();
    case ($urandom_range(0, 9))
      0:       return cmrt_pkg::REG_CURRENT;
      1:       return cmrt_pkg::REG_VELOCITY;
      2:       return cmrt_pkg::REG_POSITION;
      3:       return cmrt_pkg::REG_SET_VEL;
      4:       return cmrt_pkg::REG_SET_POS;
      5:       return cmrt_pkg::REG_MODE;
      6:       return cmrt_pkg::REG_ENABLE;
      7:       return cmrt_pkg::REG_ALARM;
      8:       return REG_UNKNOWN;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Values around the 16-bit saturation limits are favored.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 8))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'($urandom_range(0, 32767));
      3:       return 32'(-int'($urandom_range(0, 40000)));
      4:       return 32'($urandom_range(32700, 32900));
      5:       return 32'(-int'($urandom_range(32700, 32900)));
      6:       return 32'd0;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input word_t w);
    entry_report_t r;
    int gap;
    gap = $urandom_range(0, gap_limit);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    func          <= w.func;
    is_extended   <= w.is_extended;
    frame_id      <= w.frame_id;
    frame_length  <= w.frame_length;
    response_type <= w.response_type;
    register_addr <= w.register_addr;
    payload_word  <= w.payload_word;
    managed_id    <= w.managed_id;
    start         <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = track_word(w);
    entry_reports_due.insert(entry_reports_due.size(), r);
    words_sent++;
    if (w.func == cmrt_pkg::FUNC_ADD || w.func == cmrt_pkg::FUNC_CLEAR) set_updates++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (entry_reports_due.size() != 0) @(posedge clk);
  endtask

  task automatic test_read_responses();
    send_word(make_frame(11'h000, 4'd8, cmrt_pkg::RESP_READ, cmrt_pkg::REG_CURRENT,
                         32'h0001_2345));
    send_word(make_frame(11'h000, 4'd8, cmrt_pkg::RESP_READ, cmrt_pkg::REG_VELOCITY,
                         32'hFFFF_0000));
    send_word(make_frame(11'h000, 4'd6, cmrt_pkg::RESP_READ, cmrt_pkg::REG_POSITION,
                         32'h8000_0000));
    send_word(make_frame(11'h0FF, 4'd7, cmrt_pkg::RESP_READ, cmrt_pkg::REG_CURRENT,
                         32'hFFFF_8000));
    send_word(make_frame(11'h0FF, 4'd8, cmrt_pkg::RESP_READ, cmrt_pkg::REG_MODE,
                         32'h0000_0003));
    send_word(make_frame(11'h0FF, 4'd8, cmrt_pkg::RESP_READ, cmrt_pkg::REG_ENABLE,
                         32'h0000_0001));
    send_word(make_frame(11'h0FF, 4'd8, cmrt_pkg::RESP_READ, cmrt_pkg::REG_ALARM,
                         32'h0000_0100));
    send_word(make_frame(11'h0FF, 4'd8, cmrt_pkg::RESP_READ, cmrt_pkg::REG_ALARM,
                         32'h0000_0000));
    send_word(make_frame(11'h000, 4'd8, cmrt_pkg::RESP_READ, REG_UNKNOWN, 32'hFFFF_FFFF));
    send_word(make_frame(11'h000, 4'd8, RESP_UNKNOWN, cmrt_pkg::REG_POSITION,
                         32'h1234_5678));
  endtask

  task automatic test_short_payload();
    // Position read too short to carry the value: entry is marked but reads zero.
    send_word(make_frame(11'h001, 4'd5, cmrt_pkg::RESP_READ, cmrt_pkg::REG_POSITION,
                         32'hFFFF_FFFF));
    // Without byte 2 the ack state reads as zero, which counts as a failure.
    send_word(make_frame(11'h001, 4'd2, cmrt_pkg::RESP_WRITE_ACK, cmrt_pkg::REG_SET_VEL,
                         32'h0100_0000));
    send_word(make_frame(11'h001, 4'd3, cmrt_pkg::RESP_WRITE_ACK, cmrt_pkg::REG_SET_POS,
                         32'h01FF_FFFF));
    send_word(make_frame(11'h001, 4'd15, cmrt_pkg::RESP_READ, cmrt_pkg::REG_MODE,
                         32'h0000_0003));
  endtask

  task automatic test_write_acks();
    send_word(make_frame(11'h002, 4'd8, cmrt_pkg::RESP_WRITE_ACK, cmrt_pkg::REG_SET_POS,
                         32'hFF00_0000));
    send_word(make_frame(11'h002, 4'd8, cmrt_pkg::RESP_WRITE_ACK, cmrt_pkg::REG_MODE,
                         32'h0000_0000));
    send_word(make_frame(11'h002, 4'd4, cmrt_pkg::RESP_WRITE_ACK, cmrt_pkg::REG_ENABLE,
                         32'h8000_0000));
    send_word(make_frame(11'h002, 4'd8, cmrt_pkg::RESP_WRITE_ACK, cmrt_pkg::REG_ALARM,
                         32'h0200_0000));
    send_word(make_frame(11'h002, 4'd8, cmrt_pkg::RESP_WRITE_ACK, REG_UNKNOWN,
                         32'hFF00_0000));
    send_word(make_frame(11'h002, 4'd8, cmrt_pkg::RESP_WRITE_ACK, cmrt_pkg::REG_SET_VEL,
                         32'h0500_0000));
  endtask

  task automatic test_rejects();
    word_t w;
    w = make_frame(11'h003, 4'd8, cmrt_pkg::RESP_READ, cmrt_pkg::REG_POSITION,
                   32'h0000_0042);
    w.is_extended = 1'b1;
    send_word(w);
    send_word(make_frame(11'h003, 4'd1, cmrt_pkg::RESP_READ, cmrt_pkg::REG_POSITION,
                         32'h0000_0042));
    send_word(make_frame(11'h100, 4'd8, cmrt_pkg::RESP_READ, cmrt_pkg::REG_POSITION,
                         32'h0000_0042));
    send_word(make_control(FUNC_UNUSED, 8'hFF));
  endtask

  task automatic test_managed_set();
    send_word(make_control(cmrt_pkg::FUNC_ADD, 8'h12));
    send_word(make_control(cmrt_pkg::FUNC_ADD, 8'h12));
    send_word(make_frame(11'h012, 4'd8, cmrt_pkg::RESP_READ, cmrt_pkg::REG_VELOCITY,
                         32'h0000_1234));
    send_word(make_frame(11'h013, 4'd8, cmrt_pkg::RESP_READ, cmrt_pkg::REG_VELOCITY,
                         32'h0000_1234));
    send_word(make_control(cmrt_pkg::FUNC_CLEAR, 8'h12));
    send_word(make_frame(11'h013, 4'd8, cmrt_pkg::RESP_READ, cmrt_pkg::REG_VELOCITY,
                         32'h0000_4321));
  endtask

  task automatic test_random_traffic();
    word_t w;
    int    roll;
    int    base;
    int    in_block;
    base = words_sent;
    while (words_sent - base < ITEM_TARGET) begin
      // Alternate back-to-back stretches with gappy ones.
      gap_limit = ($urandom_range(0, 2) == 0) ? 0 : 8;
      for (in_block = 0; in_block < BLOCK_WORDS; in_block++) begin
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
          w = make_control(cmrt_pkg::FUNC_ADD, ($urandom_range(0, 3) == 0) ?
                           8'($urandom_range(0, 255)) : hot_motor());
        end else if (roll < 7) begin
          w = make_control(cmrt_pkg::FUNC_CLEAR, 8'($urandom_range(0, 255)));
        end else if (roll < 90) begin
          w = make_frame({3'b000, hot_motor()}, 4'($urandom_range(6, 8)),
                         (roll < 55) ? cmrt_pkg::RESP_READ :
                         (roll < 82) ? cmrt_pkg::RESP_WRITE_ACK : 8'($urandom_range(0, 255)),
                         pick_register(), pick_value());
          if ($urandom_range(0, 4) == 0) w.frame_length = 4'($urandom_range(2, 15));
          if (w.response_type == cmrt_pkg::RESP_WRITE_ACK && $urandom_range(0, 1) == 1)
            w.payload_word[31:24] = ($urandom_range(0, 1) == 1) ? cmrt_pkg::ACK_OK :
                                                                  cmrt_pkg::ACK_OK_ALT;
          if (w.register_addr == cmrt_pkg::REG_MODE && $urandom_range(0, 1) == 1)
            w.payload_word[7:0] = cmrt_pkg::MODE_VELOCITY;
          w.managed_id = 8'($urandom_range(0, 255));
        end else begin
          w.func          = 2'($urandom_range(0, 3));
          w.is_extended   = 1'($urandom_range(0, 1));
          w.frame_id      = 11'($urandom_range(0, 2047));
          w.frame_length  = 4'($urandom_range(0, 15));
          w.response_type = 8'($urandom_range(0, 255));
          w.register_addr = 8'($urandom_range(0, 255));
          w.payload_word  = $urandom;
          w.managed_id    = 8'($urandom_range(0, 255));
        end
        send_word(w);
      end
      if (words_sent - base < 2 * BLOCK_WORDS || $urandom_range(0, 1) == 1)
        drain_results();
    end
  endtask

  function automatic bit field_ok(input string name, input logic [31:0] want,
                                  input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin : check_results
    entry_report_t want;
    bit            ok;
    if (!rst && done) begin
      if (entry_reports_due.size() == 0) begin
        $display("%0t ns: result word with nothing outstanding, expected none, actual motor %0h",
                 $time, motor_id);
        mismatch_count++;
      end else begin
        want = entry_reports_due.pop_front();
        ok = 1'b1;
        ok &= field_ok("accepted", want.accepted, accepted);
        ok &= field_ok("motor_id", want.motor_id, motor_id);
        ok &= field_ok("position", want.position, position);
        ok &= field_ok("current_ma", want.current_ma, $unsigned(current_ma));
        ok &= field_ok("speed", want.speed, $unsigned(speed));
        ok &= field_ok("velocity_mode", want.velocity_mode, velocity_mode);
        ok &= field_ok("enabled", want.enabled, enabled);
        ok &= field_ok("fault", want.fault, fault);
        ok &= field_ok("received_mask", want.received_mask, received_mask);
        ok &= field_ok("write_failed", want.write_failed, write_failed);
        ok &= field_ok("resync_valid", want.resync_valid, resync_valid);
        ok &= field_ok("resync_register", want.resync_register, resync_register);
        if (!ok) mismatch_count++;
        if (want.accepted) frames_taken++;
        if (want.resync_valid) resyncs_seen++;
      end
    end
  end

  initial begin
    rst           = 1'b1;
    start         = 1'b0;
    func          = cmrt_pkg::FUNC_FRAME;
    is_extended   = 1'b0;
    frame_id      = '0;
    frame_length  = '0;
    response_type = '0;
    register_addr = '0;
    payload_word  = '0;
    managed_id    = '0;
    for (int i = 0; i < MOTOR_SLOTS; i++) begin
      pos_cache[i]   = '0;
      cur_cache[i]   = '0;
      spd_cache[i]   = '0;
      flag_cache[i]  = '0;
      managed_map[i] = 1'b0;
    end
    managed_total   = '0;
    gap_limit       = 8;
    words_sent      = 0;
    set_updates     = 0;
    frames_taken    = 0;
    resyncs_seen    = 0;
    mismatch_count  = 0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_read_responses();
    test_short_payload();
    test_write_acks();
    test_rejects();
    test_managed_set();
    test_random_traffic();

    drain_results();
    repeat (8) @(posedge clk);

    $display("Sent %0d words (%0d managed-set updates); %0d frames were taken and %0d",
             words_sent, set_updates, frames_taken, resyncs_seen);
    $display("asked for a read-back, with gaps from none up to eight cycles.");
    if (mismatch_count == 0 && entry_reports_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/cmrt_pkg.sv
rtl/core/can_motor_response_tracker_top.sv
rtl/core/cmrt_checker.sv
tb/sv/can_motor_response_tracker_top_tb.sv
